// ===== rtl/uri_request_target_parser_core_assert.svh =====
// Assertion macros for the URI request-target parser checker.
// Uses clk and rst_n of the scope that expands them.
`ifndef URI_REQUEST_TARGET_PARSER_CORE_ASSERT_SVH
`define URI_REQUEST_TARGET_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define URTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define URTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/urtp_pkg.sv =====
// Shared types, codes and character classes for the URI request-target parser.
// No dependencies.
package urtp_pkg;

  // front/back queue
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);
  localparam int OPS_MAX = 4;

  // result kinds
  localparam logic [3:0] K_WORD   = 4'd0;
  localparam logic [3:0] K_HOST   = 4'd1;
  localparam logic [3:0] K_PORT   = 4'd2;
  localparam logic [3:0] K_PATH   = 4'd3;
  localparam logic [3:0] K_QUERY  = 4'd4;
  localparam logic [3:0] K_FRAG   = 4'd5;
  localparam logic [3:0] K_SCHEME = 4'd6;
  localparam logic [3:0] K_WHOST  = 4'd7;
  localparam logic [3:0] K_STATUS = 4'd8;

  // target forms
  localparam logic [2:0] FORM_UNKNOWN   = 3'd0;
  localparam logic [2:0] FORM_ORIGIN    = 3'd1;
  localparam logic [2:0] FORM_ABSOLUTE  = 3'd2;
  localparam logic [2:0] FORM_AUTHORITY = 3'd3;
  localparam logic [2:0] FORM_ASTERISK  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCHAR  = 3'd1;
  localparam logic [2:0] ST_CUT      = 3'd2;
  localparam logic [2:0] ST_BADHEX   = 3'd3;
  localparam logic [2:0] ST_EARLY    = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_ASTERISK = 3'd6;

  // characters
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // scheme prefix matcher: 0..4 chars matched, else mismatch
  localparam logic [2:0] MATCH_FULL = 3'd4;
  localparam logic [2:0] MATCH_FAIL = 3'd5;

  // queue ops: one feed byte, an escape failure, or the end mark
  typedef enum logic [1:0] {
    OP_FEED,
    OP_FAIL,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   op;
    logic [7:0] data;   // byte, fail code, or escape-pending flag in bit 0
  } op_t;

  typedef struct packed {
    op_t [OPS_MAX-1:0] ops;
    logic [1:0]        last_idx;
  } bundle_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] kind;
    logic [2:0] form;
    logic [2:0] status;
    logic       last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_digit(c)) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  function automatic logic is_unres(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c inside {8'h2D, 8'h2E, 8'h5F, 8'h7E});
  endfunction

  function automatic logic is_sub(input logic [7:0] c);
    return c inside {8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
                     8'h3B, 8'h3D};
  endfunction

  function automatic logic is_pchar(input logic [7:0] c);
    return is_unres(c) || is_sub(c) || c == CH_COLON || c == 8'h40;
  endfunction

  function automatic logic is_qf(input logic [7:0] c);
    return is_pchar(c) || c == CH_SLASH || c == CH_QMARK;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
  endfunction

  // "http"
  function automatic logic [7:0] http_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h68;
      2'd1:    r = 8'h74;
      2'd2:    r = 8'h74;
      default: r = 8'h70;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/urtp_front.sv =====
// Front end: escape handling, turns each input item into a bundle of queue ops.
// Depends on urtp_pkg.
module urtp_front import urtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_no_byte,
  input  logic       in_end_of_target,
  output logic       push,
  output bundle_t    push_data
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_PCT,
    ESC_DIGIT
  } esc_t;

  esc_t       esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;

  logic [1:0]       nfeed;
  logic [2:0][7:0]  fb;
  logic             fail;
  logic [2:0]       fail_code;
  logic [7:0]       dec;
  logic [2:0]       nops;
  op_t [OPS_MAX-1:0] ops;

  always_comb begin
    esc_nxt   = esc_r;
    held_nxt  = held_r;
    nfeed     = 2'd0;
    fb        = '0;
    fail      = 1'b0;
    fail_code = ST_OK;
    dec       = {hex_val(held_r), hex_val(in_byte)};

    if (!in_no_byte) begin
      case (esc_r)
        ESC_IDLE: begin
          if (in_byte == CH_PCT) begin
            if (in_end_of_target) begin
              fail      = 1'b1;
              fail_code = ST_CUT;
            end else begin
              esc_nxt = ESC_PCT;
            end
          end else begin
            fb[0] = in_byte;
            nfeed = 2'd1;
          end
        end
        ESC_PCT: begin
          if (in_end_of_target) begin
            fail      = 1'b1;
            fail_code = ST_CUT;
          end else if (!is_hex(in_byte)) begin
            fail      = 1'b1;
            fail_code = ST_BADHEX;
          end else begin
            held_nxt = in_byte;
            esc_nxt  = ESC_DIGIT;
          end
        end
        ESC_DIGIT: begin
          esc_nxt = ESC_IDLE;
          if (!is_hex(in_byte)) begin
            fail      = 1'b1;
            fail_code = ST_BADHEX;
          end else if (is_unres(dec)) begin
            fb[0] = dec;
            nfeed = 2'd1;
          end else begin
            // not unreserved: pass the escape through as text
            fb    = {in_byte, held_r, CH_PCT};
            nfeed = 2'd3;
          end
        end
        default: esc_nxt = ESC_IDLE;
      endcase
    end

    ops = '0;
    if (fail) begin
      ops[0].op   = OP_FAIL;
      ops[0].data = {5'd0, fail_code};
      nops        = 3'd1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nfeed) begin
          ops[i].op   = OP_FEED;
          ops[i].data = fb[i];
        end
      end
      nops = {1'b0, nfeed};
    end

    if (in_end_of_target) begin
      ops[nops[1:0]].op   = OP_END;
      ops[nops[1:0]].data = {7'd0, esc_nxt != ESC_IDLE};
      nops                = nops + 3'd1;
      esc_nxt             = ESC_IDLE;
    end

    push               = take && (nops != 3'd0);
    push_data.ops      = ops;
    push_data.last_idx = 2'(nops - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= ESC_IDLE;
      held_r <= '0;
    end else if (take) begin
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/urtp_fifo.sv =====
// Short bundle queue between the front and back ends.
// Depends on urtp_pkg.
module urtp_fifo import urtp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    nonempty,
  output bundle_t head
);

  bundle_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r;

  assign full     = (count_r == QCW'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

endmodule

// ===== rtl/urtp_back.sv =====
// Back end: target-form state machine, one queued op per cycle unless stalled, output register.
// Depends on urtp_pkg.
module urtp_back import urtp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  bundle_t head,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res_out
);

  typedef enum logic [3:0] {
    PH_START,
    PH_WORD,
    PH_SCHEME,
    PH_HOST_TRIAL,
    PH_IPV6,
    PH_AFTER_IPV6,
    PH_REGNAME,
    PH_PORT,
    PH_PATH_TRIAL,
    PH_PATH,
    PH_QUERY,
    PH_FRAGMENT,
    PH_DONE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] form_r, form_nxt;
  logic [1:0] slash_r, slash_nxt;
  logic [2:0] match_r, match_nxt;
  logic       err_r, err_nxt;
  logic [1:0] idx_r;
  logic       out_valid_r;
  res_t       out_res_r;

  op_t        op;
  logic       step, last_op;
  res_t       res;
  logic       res_vld;
  logic [7:0] c, lc;
  logic       pct, bad;
  logic [2:0] bad_code, end_code;
  logic [2:0] match_w;
  logic [1:0] slash_inc;

  function automatic res_t mk_data(input logic [7:0] b, input logic [3:0] k);
    res_t r;
    r.data   = b;
    r.kind   = k;
    r.form   = FORM_UNKNOWN;
    r.status = ST_OK;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [2:0] code);
    res_t r;
    r.data   = 8'h00;
    r.kind   = K_STATUS;
    r.form   = FORM_UNKNOWN;
    r.status = code;
    r.last   = 1'b1;
    return r;
  endfunction

  assign op        = head.ops[idx_r];
  assign step      = q_valid && (!out_valid_r || res_ready);
  assign last_op   = (idx_r == head.last_idx);
  assign pop       = step && last_op;
  assign res_valid = out_valid_r;
  assign res_out   = out_res_r;

  always_comb begin
    phase_nxt = phase_r;
    form_nxt  = form_r;
    slash_nxt = slash_r;
    match_nxt = match_r;
    err_nxt   = err_r;
    res       = mk_data(8'h00, K_WORD);
    res_vld   = 1'b0;
    bad       = 1'b0;
    bad_code  = ST_BADCHAR;
    end_code  = ST_OK;
    c         = op.data;
    pct       = (c == CH_PCT);
    lc        = to_lower(c);
    match_w   = (match_r < MATCH_FULL && lc == http_char(match_r[1:0])) ?
                match_r + 3'd1 : MATCH_FAIL;
    slash_inc = slash_r + 2'd1;

    case (op.op)
      OP_FEED: begin
        if (!err_r) begin
          case (phase_r)
            PH_START: begin
              if (c == CH_SLASH) begin
                form_nxt  = FORM_ORIGIN;
                res       = mk_data(CH_SLASH, K_PATH);
                res_vld   = 1'b1;
                phase_nxt = PH_PATH_TRIAL;
              end else if (c == CH_STAR) begin
                form_nxt  = FORM_ASTERISK;
                phase_nxt = PH_DONE;
              end else if (c == CH_LBRACK) begin
                form_nxt  = FORM_AUTHORITY;
                phase_nxt = PH_IPV6;
              end else if ((is_pchar(c) || pct) && c != CH_COLON) begin
                match_nxt = match_w;
                res       = mk_data(lc, K_WORD);
                res_vld   = 1'b1;
                phase_nxt = PH_WORD;
              end else begin
                bad = 1'b1;
              end
            end
            PH_WORD: begin
              if (c == CH_COLON) begin
                res_vld = 1'b1;
                if (match_r == MATCH_FULL) begin
                  res       = mk_data(8'h00, K_SCHEME);
                  phase_nxt = PH_SCHEME;
                end else begin
                  form_nxt  = FORM_AUTHORITY;
                  res       = mk_data(8'h00, K_WHOST);
                  phase_nxt = PH_PORT;
                end
              end else if (is_pchar(c) || pct) begin
                match_nxt = match_w;
                res       = mk_data(lc, K_WORD);
                res_vld   = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            PH_SCHEME: begin
              slash_nxt = slash_inc;
              if (slash_inc == 2'd1 && c == CH_SLASH) begin
                // first slash of "//"
              end else if (slash_inc == 2'd2 && c == CH_SLASH) begin
                slash_nxt = 2'd0;
                form_nxt  = FORM_ABSOLUTE;
                phase_nxt = PH_HOST_TRIAL;
              end else begin
                bad = 1'b1;
              end
            end
            PH_HOST_TRIAL: begin
              if (c == CH_LBRACK) begin
                res       = mk_data(c, K_HOST);
                res_vld   = 1'b1;
                phase_nxt = PH_IPV6;
              end else if (is_unres(c) || is_sub(c) || pct) begin
                res       = mk_data(c, K_HOST);
                res_vld   = 1'b1;
                phase_nxt = PH_REGNAME;
              end else begin
                bad = 1'b1;
              end
            end
            PH_IPV6: begin
              if (c == CH_RBRACK) begin
                phase_nxt = PH_AFTER_IPV6;
              end else if (is_unres(c) || c == CH_COLON || is_sub(c)) begin
                res     = mk_data(c, K_HOST);
                res_vld = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            PH_AFTER_IPV6: begin
              if (c == CH_COLON) begin
                phase_nxt = PH_PORT;
              end else if (c == CH_SLASH) begin
                res       = mk_data(CH_SLASH, K_PATH);
                res_vld   = 1'b1;
                phase_nxt = PH_PATH_TRIAL;
              end else begin
                bad = 1'b1;
              end
            end
            PH_REGNAME: begin
              if (is_unres(c) || is_sub(c) || pct) begin
                res     = mk_data(c, K_HOST);
                res_vld = 1'b1;
              end else if (c == CH_SLASH) begin
                res       = mk_data(CH_SLASH, K_PATH);
                res_vld   = 1'b1;
                phase_nxt = PH_PATH_TRIAL;
              end else if (c == CH_COLON) begin
                phase_nxt = PH_PORT;
              end else begin
                bad = 1'b1;
              end
            end
            PH_PORT: begin
              if (is_digit(c)) begin
                res     = mk_data(c, K_PORT);
                res_vld = 1'b1;
              end else if (c == CH_SLASH) begin
                res       = mk_data(CH_SLASH, K_PATH);
                res_vld   = 1'b1;
                phase_nxt = PH_PATH_TRIAL;
              end else begin
                bad = 1'b1;
              end
            end
            PH_PATH_TRIAL: begin
              if (is_pchar(c) || pct) begin
                res       = mk_data(c, K_PATH);
                res_vld   = 1'b1;
                phase_nxt = PH_PATH;
              end else begin
                bad = 1'b1;
              end
            end
            PH_PATH: begin
              if (c == CH_SLASH || is_pchar(c) || pct) begin
                res     = mk_data(c, K_PATH);
                res_vld = 1'b1;
              end else if (c == CH_QMARK) begin
                phase_nxt = PH_QUERY;
              end else if (c == CH_HASH) begin
                phase_nxt = PH_FRAGMENT;
              end else begin
                bad = 1'b1;
              end
            end
            PH_QUERY: begin
              if (is_qf(c) || pct) begin
                res     = mk_data(c, K_QUERY);
                res_vld = 1'b1;
              end else if (c == CH_HASH) begin
                phase_nxt = PH_FRAGMENT;
              end else begin
                bad = 1'b1;
              end
            end
            PH_FRAGMENT: begin
              if (is_qf(c) || pct) begin
                res     = mk_data(c, K_FRAG);
                res_vld = 1'b1;
              end else begin
                bad = 1'b1;
              end
            end
            default: begin
              // anything after a lone asterisk
              bad      = 1'b1;
              bad_code = ST_ASTERISK;
            end
          endcase

          if (bad) begin
            res     = mk_status(bad_code);
            res_vld = 1'b1;
            err_nxt = 1'b1;
          end
          res.form = form_nxt;
        end
      end
      OP_FAIL: begin
        if (!err_r) begin
          res      = mk_status(op.data[2:0]);
          res.form = form_r;
          res_vld  = 1'b1;
          err_nxt  = 1'b1;
        end
      end
      OP_END: begin
        if (!err_r) begin
          if (op.data[0]) begin
            end_code = ST_CUT;
          end else if (phase_r == PH_START) begin
            end_code = ST_EMPTY;
          end else if (phase_r inside {PH_WORD, PH_SCHEME, PH_HOST_TRIAL}) begin
            end_code = ST_EARLY;
          end else begin
            end_code = ST_OK;
          end
          res      = mk_status(end_code);
          res.form = form_r;
          res_vld  = 1'b1;
        end
        phase_nxt = PH_START;
        form_nxt  = FORM_UNKNOWN;
        slash_nxt = 2'd0;
        match_nxt = 3'd0;
        err_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      form_r      <= FORM_UNKNOWN;
      slash_r     <= 2'd0;
      match_r     <= 3'd0;
      err_r       <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        form_r  <= form_nxt;
        slash_r <= slash_nxt;
        match_r <= match_nxt;
        err_r   <= err_nxt;
        idx_r   <= last_op ? 2'd0 : idx_r + 2'd1;
      end
      if (step && res_vld) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/uri_request_target_parser_core.sv =====
// Top level of the HTTP request-target parser: front end, bundle queue, back end.
// Depends on urtp_pkg, urtp_front, urtp_fifo, urtp_back.
//
//   channel  | signals                                          | direction
//   ---------+--------------------------------------------------+----------
//   in_      | in_valid/in_ready, in_byte, in_no_byte,          | in
//            | in_end_of_target                                 |
//   out_     | out_valid/out_ready, out_byte, out_kind,         | out
//            | out_uri_form, out_status, out_last_result        |
//
// One input item is taken per cycle while the 4-entry bundle queue has room.
// The back end retires one op per cycle unless the output is stalled: an item
// costs 0 ops (held escape byte, bare no_byte), 1 op (plain byte, decoded
// escape or escape error), 3 ops (escape passed through as text), plus 1 op
// for the end mark; that op rate sets the sustained rate.
// An input item is written into the bundle queue; with an idle queue the back
// end then decodes it and loads its first result into the result register.
// rst_n is synchronous and active low; it empties the queue and returns the
// parser to its start state. A stalled output holds the back end; the front
// keeps taking items until the queue fills.
module uri_request_target_parser_core import urtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_no_byte,
  input  logic       in_end_of_target,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [3:0] out_kind,
  output logic [2:0] out_uri_form,
  output logic [2:0] out_status,
  output logic       out_last_result
);

  logic    take;
  logic    push, pop;
  logic    q_full, q_nonempty;
  bundle_t push_data, head;
  res_t    res;

  // Ready depends only on queue room, never on the item itself.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  urtp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .in_byte          (in_byte),
    .in_no_byte       (in_no_byte),
    .in_end_of_target (in_end_of_target),
    .push             (push),
    .push_data        (push_data)
  );

  urtp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  urtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .head      (head),
    .pop       (pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_out   (res)
  );

  // result register fields out to the ports
  assign out_byte        = res.data;
  assign out_kind        = res.kind;
  assign out_uri_form    = res.form;
  assign out_status      = res.status;
  assign out_last_result = res.last;

endmodule

// ===== rtl/urtp_checker.sv =====
// Port-level checker for the request-target parser, bound to the top level.
// Depends on urtp_pkg and uri_request_target_parser_core_assert.svh.
`include "uri_request_target_parser_core_assert.svh"

module urtp_checker import urtp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [3:0] out_kind,
  input logic [2:0] out_uri_form,
  input logic [2:0] out_status,
  input logic       out_last_result
);

  // stalled result holds
  `URTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind) && $stable(out_status) && $stable(out_last_result), "result changed while stalled")

  // only the status result closes a target
  `URTP_ASSERT_NOW(a_last_iff_status, out_valid, (out_kind == K_STATUS) == (out_last_result == 1'b1), "last flag and status kind disagree")

  // data results carry ok status
  `URTP_ASSERT_NOW(a_data_ok, out_valid && out_kind != K_STATUS, out_status == ST_OK, "data result with nonzero status")

  // authority host marker comes with authority form
  `URTP_ASSERT_NOW(a_whost_form, out_valid && out_kind == K_WHOST, out_uri_form == FORM_AUTHORITY && out_byte == 8'h00, "host marker without authority form")

  // port bytes are decimal digits
  `URTP_ASSERT_NOW(a_port_digit, out_valid && out_kind == K_PORT, out_byte >= 8'h30 && out_byte <= 8'h39, "non-digit port byte")

endmodule

bind uri_request_target_parser_core urtp_checker u_urtp_checker (.*);
